/* hw/rtl/rtnp_pkg.sv */
// ----------------------------------------------------------------------------
// rtnp_pkg
// shared widths, character codes, error codes and the control/status structs
// of the ringtone text note parser
// ----------------------------------------------------------------------------
package rtnp_pkg;

    localparam int MAX_NAME_LEN = 10;
    localparam int NAME_CNT_W   = 4;
    localparam int ACC_W        = 17;
    localparam int WHOLE_W      = 18;
    localparam int LEN_W        = 25;
    localparam int TEMPO_W      = 16;
    localparam int OCT_W        = 3;
    localparam int DUR_W        = 6;
    localparam int ERR_W        = 4;
    localparam int PITCH_W      = 4;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [ACC_W-1:0]   ACC_MAX      = 17'd131071;
    localparam int                 MS_WHOLE_INT = 240000;
    localparam logic [WHOLE_W-1:0] MS_WHOLE     = WHOLE_W'(MS_WHOLE_INT);

    localparam logic [OCT_W-1:0]   OCT_RESET    = 3'd6;
    localparam logic [DUR_W-1:0]   DUR_RESET    = 6'd4;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET  = 16'd63;
    localparam logic [WHOLE_W-1:0] WHOLE_RESET  = WHOLE_W'(MS_WHOLE_INT / 63);

    localparam logic [CFG_ADDR_W-1:0] CFG_OCTAVE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DURATION = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMPO    = 2'd2;

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_O  = 8'h6f;
    localparam logic [7:0] CH_LO_D  = 8'h64;
    localparam logic [7:0] CH_LO_B  = 8'h62;

    localparam logic [ERR_W-1:0] ERR_NONE       = 4'd0;
    localparam logic [ERR_W-1:0] ERR_END_NAME   = 4'd1;
    localparam logic [ERR_W-1:0] ERR_NAME_LONG  = 4'd2;
    localparam logic [ERR_W-1:0] ERR_END_CTRL   = 4'd3;
    localparam logic [ERR_W-1:0] ERR_NO_DIGITS  = 4'd4;
    localparam logic [ERR_W-1:0] ERR_OCT_VAL    = 4'd5;
    localparam logic [ERR_W-1:0] ERR_DUR_VAL    = 4'd6;
    localparam logic [ERR_W-1:0] ERR_TEMPO_VAL  = 4'd7;
    localparam logic [ERR_W-1:0] ERR_PAIR_SEP   = 4'd8;
    localparam logic [ERR_W-1:0] ERR_NOTE_DUR   = 4'd9;
    localparam logic [ERR_W-1:0] ERR_NOTE_OCT   = 4'd10;
    localparam logic [ERR_W-1:0] ERR_NOTE_SEP   = 4'd11;

    localparam logic [PITCH_W-1:0] PITCH_PAUSE  = 4'd12;

    typedef struct packed {
        logic             use_held;
        logic             start_song;
        logic             name_inc;
        logic             clear_num;
        logic             accumulate;
        logic             set_letter;
        logic             apply;
        logic             set_dur;
        logic             load_note;
        logic             pitch_inc;
        logic             set_dotted;
        logic             div_start;
        logic             emit;
        logic             emit_note;
        logic             emit_end;
        logic [ERR_W-1:0] emit_err;
    } rtnp_cmd_t;

    typedef struct packed {
        logic             is_zero;
        logic             is_space;
        logic             is_colon;
        logic             is_comma;
        logic             is_eq;
        logic             is_hash;
        logic             is_dot;
        logic             is_digit;
        logic             pitch_valid;
        logic             letter_b;
        logic             name_full;
        logic             digit_seen;
        logic [ERR_W-1:0] pair_err;
        logic             dur_ok;
        logic             oct_ok;
        logic             sharp_ok;
        logic             out_free;
        logic             div_busy;
        logic             div_done;
    } rtnp_stat_t;

    function automatic logic valid_duration(input logic [ACC_W-1:0] d);
        return (d != '0) && (d <= ACC_W'(32)) && ((d & (d - ACC_W'(1))) == '0);
    endfunction

endpackage

/* hw/rtl/rtnp_div.sv */
// ----------------------------------------------------------------------------
// rtnp_div
// restoring divider, one quotient bit a cycle: whole note length in ms
// ----------------------------------------------------------------------------
module rtnp_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rtnp_pkg::TEMPO_W-1:0]   divisor,
    output logic                           busy,
    output logic                           done,
    output logic [rtnp_pkg::WHOLE_W-1:0]   quotient
);
    import rtnp_pkg::*;

    logic [TEMPO_W-1:0] den_reg;
    logic [TEMPO_W-1:0] rem_reg;
    logic [WHOLE_W-1:0] quo_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [TEMPO_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[WHOLE_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(WHOLE_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= (divisor == '0) ? TEMPO_W'(1) : divisor;
            rem_reg <= '0;
            quo_reg <= MS_WHOLE;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? TEMPO_W'(trial - {1'b0, den_reg}) : trial[TEMPO_W-1:0];
            quo_reg <= {quo_reg[WHOLE_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/rtnp_dp.sv */
// ----------------------------------------------------------------------------
// rtnp_dp
// parser datapath: settings, number accumulator, song defaults, note fields,
// length scaling and the result register
// ----------------------------------------------------------------------------
module rtnp_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rtnp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rtnp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [7:0]                        char_in,
    input  logic                              char_capture,
    input  rtnp_pkg::rtnp_cmd_t               cmd,
    output rtnp_pkg::rtnp_stat_t              stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              out_note_ready,
    output logic                              out_is_pause,
    output logic [3:0]                        out_semitone,
    output logic [rtnp_pkg::OCT_W-1:0]        out_octave,
    output logic [rtnp_pkg::LEN_W-1:0]        out_length,
    output logic                              out_song_end,
    output logic [rtnp_pkg::ERR_W-1:0]        out_error
);
    import rtnp_pkg::*;

    logic [OCT_W-1:0]      init_oct_reg;
    logic [DUR_W-1:0]      init_dur_reg;
    logic [TEMPO_W-1:0]    init_tempo_reg;
    logic [7:0]            char_reg;
    logic [NAME_CNT_W-1:0] name_cnt_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic                  seen_reg;
    logic [7:0]            letter_reg;
    logic [OCT_W-1:0]      def_oct_reg;
    logic [DUR_W-1:0]      def_dur_reg;
    logic [WHOLE_W-1:0]    whole_reg;
    logic [DUR_W-1:0]      note_dur_reg;
    logic [PITCH_W-1:0]    pitch_reg;
    logic                  pause_reg;
    logic                  dotted_reg;
    logic                  out_valid_reg;
    logic                  o_note_reg;
    logic                  o_pause_reg;
    logic [3:0]            o_semi_reg;
    logic [OCT_W-1:0]      o_oct_reg;
    logic [LEN_W-1:0]      o_len_reg;
    logic                  o_end_reg;
    logic [ERR_W-1:0]      o_err_reg;

    logic [7:0]            c;
    logic                  digit;
    logic [PITCH_W-1:0]    char_pitch;
    logic [ACC_W-1:0]      v_dur;
    logic [ACC_W-1:0]      v_oct;
    logic [ACC_W+3:0]      acc_mul;
    logic [ACC_W-1:0]      acc_sat;
    logic [ERR_W-1:0]      pair_err;
    logic [LEN_W-1:0]      len_sum;
    logic [LEN_W-1:0]      len_val;
    logic [TEMPO_W-1:0]    div_op;
    logic                  div_busy;
    logic                  div_done;
    logic [WHOLE_W-1:0]    div_q;

    assign c     = cmd.use_held ? char_reg : char_in;
    assign digit = (c >= CH_ZERO) && (c <= CH_NINE);

    always_comb
    begin
        unique case (c)
            8'h43:   char_pitch = 4'd0;
            8'h44:   char_pitch = 4'd2;
            8'h45:   char_pitch = 4'd4;
            8'h46:   char_pitch = 4'd5;
            8'h47:   char_pitch = 4'd7;
            8'h41:   char_pitch = 4'd9;
            8'h42:   char_pitch = 4'd11;
            8'h50:   char_pitch = PITCH_PAUSE;
            default: char_pitch = 4'd15;
        endcase
    end

    assign v_dur = (acc_reg != '0) ? acc_reg : ACC_W'(def_dur_reg);
    assign v_oct = (acc_reg != '0) ? acc_reg : ACC_W'(def_oct_reg);

    assign acc_mul = (ACC_W+4)'({acc_reg, 3'b000}) + (ACC_W+4)'({acc_reg, 1'b0})
                   + (ACC_W+4)'(c - CH_ZERO);
    assign acc_sat = (acc_mul > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : acc_mul[ACC_W-1:0];

    always_comb
    begin
        pair_err = ERR_NONE;
        if (!seen_reg)
            pair_err = ERR_NO_DIGITS;
        else if (letter_reg == CH_LO_O)
        begin
            if (acc_reg < ACC_W'(4) || acc_reg > ACC_W'(7))
                pair_err = ERR_OCT_VAL;
        end
        else if (letter_reg == CH_LO_D)
        begin
            if (!valid_duration(acc_reg))
                pair_err = ERR_DUR_VAL;
        end
        else if (letter_reg == CH_LO_B)
        begin
            if (acc_reg == '0 || acc_reg > ACC_W'(65535))
                pair_err = ERR_TEMPO_VAL;
        end
    end

    assign len_sum = LEN_W'({whole_reg, 6'b0})
                   + (dotted_reg ? LEN_W'({whole_reg, 5'b0}) : '0);

    always_comb
    begin
        case (note_dur_reg)
            6'd1:    len_val = len_sum;
            6'd2:    len_val = len_sum >> 1;
            6'd4:    len_val = len_sum >> 2;
            6'd8:    len_val = len_sum >> 3;
            6'd16:   len_val = len_sum >> 4;
            6'd32:   len_val = len_sum >> 5;
            default: len_val = '0;
        endcase
    end

    assign div_op = cmd.start_song ? init_tempo_reg : acc_reg[TEMPO_W-1:0];

    rtnp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (div_op),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        stat.is_zero     = (c == CH_END);
        stat.is_space    = (c == CH_SPACE);
        stat.is_colon    = (c == CH_COLON);
        stat.is_comma    = (c == CH_COMMA);
        stat.is_eq       = (c == CH_EQ);
        stat.is_hash     = (c == CH_HASH);
        stat.is_dot      = (c == CH_DOT);
        stat.is_digit    = digit;
        stat.pitch_valid = (char_pitch != 4'd15);
        stat.letter_b    = (letter_reg == CH_LO_B);
        stat.name_full   = (name_cnt_reg >= NAME_CNT_W'(MAX_NAME_LEN));
        stat.digit_seen  = seen_reg;
        stat.pair_err    = pair_err;
        stat.dur_ok      = valid_duration(v_dur);
        stat.oct_ok      = (v_oct >= ACC_W'(4)) && (v_oct <= ACC_W'(7));
        stat.sharp_ok    = !pause_reg && (pitch_reg == 4'd0 || pitch_reg == 4'd2
                         || pitch_reg == 4'd5 || pitch_reg == 4'd7 || pitch_reg == 4'd9);
        stat.out_free    = !out_valid_reg || out_ready;
        stat.div_busy    = div_busy;
        stat.div_done    = div_done;
    end

    // settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_oct_reg   <= OCT_RESET;
            init_dur_reg   <= DUR_RESET;
            init_tempo_reg <= TEMPO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_OCTAVE:   init_oct_reg   <= cfg_wdata[OCT_W-1:0];
                CFG_DURATION: init_dur_reg   <= cfg_wdata[DUR_W-1:0];
                CFG_TEMPO:    init_tempo_reg <= cfg_wdata[TEMPO_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_capture)
            char_reg <= char_in;
    end

    // song state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_cnt_reg <= '0;
            acc_reg      <= '0;
            seen_reg     <= 1'b0;
            letter_reg   <= '0;
            def_oct_reg  <= OCT_RESET;
            def_dur_reg  <= DUR_RESET;
            whole_reg    <= WHOLE_RESET;
            note_dur_reg <= '0;
            pitch_reg    <= '0;
            pause_reg    <= 1'b0;
            dotted_reg   <= 1'b0;
        end
        else
        begin
            if (div_done)
                whole_reg <= div_q;
            if (cmd.start_song)
            begin
                name_cnt_reg <= '0;
                acc_reg      <= '0;
                seen_reg     <= 1'b0;
                letter_reg   <= '0;
                def_oct_reg  <= init_oct_reg;
                def_dur_reg  <= init_dur_reg;
                note_dur_reg <= '0;
                pitch_reg    <= '0;
                pause_reg    <= 1'b0;
                dotted_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.name_inc)
                    name_cnt_reg <= name_cnt_reg + NAME_CNT_W'(1);
                if (cmd.apply)
                begin
                    if (letter_reg == CH_LO_O)
                        def_oct_reg <= acc_reg[OCT_W-1:0];
                    else if (letter_reg == CH_LO_D)
                        def_dur_reg <= acc_reg[DUR_W-1:0];
                end
                if (cmd.set_dur)
                    note_dur_reg <= v_dur[DUR_W-1:0];
                if (cmd.clear_num)
                begin
                    acc_reg  <= '0;
                    seen_reg <= 1'b0;
                end
                else if (cmd.accumulate)
                begin
                    acc_reg  <= acc_sat;
                    seen_reg <= 1'b1;
                end
                if (cmd.set_letter)
                    letter_reg <= c;
                if (cmd.load_note)
                begin
                    pause_reg  <= (char_pitch == PITCH_PAUSE);
                    pitch_reg  <= (char_pitch == PITCH_PAUSE) ? '0 : char_pitch;
                    dotted_reg <= 1'b0;
                end
                if (cmd.pitch_inc)
                    pitch_reg <= pitch_reg + PITCH_W'(1);
                if (cmd.set_dotted)
                    dotted_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_note_reg  <= cmd.emit_note;
            o_pause_reg <= cmd.emit_note && pause_reg;
            o_semi_reg  <= (cmd.emit_note && !pause_reg) ? pitch_reg : '0;
            o_oct_reg   <= cmd.emit_note ? v_oct[OCT_W-1:0] : '0;
            o_len_reg   <= cmd.emit_note ? len_val : '0;
            o_end_reg   <= cmd.emit_end;
            o_err_reg   <= cmd.emit_err;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_note_ready = o_note_reg;
    assign out_is_pause   = o_pause_reg;
    assign out_semitone   = o_semi_reg;
    assign out_octave     = o_oct_reg;
    assign out_length     = o_len_reg;
    assign out_song_end   = o_end_reg;
    assign out_error      = o_err_reg;

endmodule

/* hw/rtl/rtnp_ctrl.sv */
// ----------------------------------------------------------------------------
// rtnp_ctrl
// parser controller: song section tracking and per-character sequencing
// ----------------------------------------------------------------------------
module rtnp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  char_capture,
    input  rtnp_pkg::rtnp_stat_t  stat,
    output rtnp_pkg::rtnp_cmd_t   cmd
);
    import rtnp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    localparam logic [3:0] PH_NAME  = 4'd0;
    localparam logic [3:0] PH_KEY   = 4'd1;
    localparam logic [3:0] PH_EQ    = 4'd2;
    localparam logic [3:0] PH_VAL   = 4'd3;
    localparam logic [3:0] PH_NDUR  = 4'd4;
    localparam logic [3:0] PH_NEQ   = 4'd5;
    localparam logic [3:0] PH_NVAL  = 4'd6;
    localparam logic [3:0] PH_SHARP = 4'd7;
    localparam logic [3:0] PH_DOT   = 4'd8;
    localparam logic [3:0] PH_OCT   = 4'd9;
    localparam logic [3:0] PH_HALT  = 4'd10;

    logic [1:0] st_reg, st_next;
    logic [3:0] ph_reg, ph_next;
    logic       cont_reg, cont_next;
    logic       step_en;
    logic       cont;
    logic       fail;
    logic [ERR_W-1:0] fail_code;
    rtnp_cmd_t  c_cmd;

    assign in_ready     = (st_reg == ST_IDLE) && stat.out_free;
    assign char_capture = in_valid && in_ready;
    assign step_en      = (char_capture && !stat.is_space)
                        || (st_reg == ST_EXEC && stat.out_free);

    always_comb
    begin
        c_cmd     = '0;
        ph_next   = ph_reg;
        cont      = 1'b0;
        fail      = 1'b0;
        fail_code = ERR_NONE;
        unique case (ph_reg)
            PH_NAME:
            begin
                if (stat.is_zero)
                begin
                    fail = 1'b1; fail_code = ERR_END_NAME;
                end
                else if (stat.is_colon)
                    ph_next = PH_KEY;
                else if (stat.name_full)
                begin
                    fail = 1'b1; fail_code = ERR_NAME_LONG;
                end
                else
                    c_cmd.name_inc = 1'b1;
            end
            PH_KEY:
            begin
                if (stat.is_zero)
                begin
                    fail = 1'b1; fail_code = ERR_END_CTRL;
                end
                else
                begin
                    c_cmd.clear_num = 1'b1;
                    if (stat.is_colon)
                        ph_next = PH_NDUR;
                    else
                    begin
                        c_cmd.set_letter = 1'b1;
                        ph_next = PH_EQ;
                    end
                end
            end
            PH_EQ, PH_NEQ:
            begin
                ph_next = (ph_reg == PH_EQ) ? PH_VAL : PH_NVAL;
                cont    = !stat.is_eq;
            end
            PH_VAL, PH_NVAL:
            begin
                if (stat.is_digit)
                    c_cmd.accumulate = 1'b1;
                else if (stat.pair_err != ERR_NONE)
                begin
                    fail = 1'b1; fail_code = stat.pair_err;
                end
                else
                begin
                    c_cmd.apply     = 1'b1;
                    c_cmd.clear_num = 1'b1;
                    c_cmd.div_start = stat.letter_b;
                    if (ph_reg == PH_NVAL)
                    begin
                        ph_next = PH_NDUR;
                        cont    = !stat.is_comma;
                    end
                    else if (stat.is_comma)
                        ph_next = PH_KEY;
                    else if (stat.is_colon)
                        ph_next = PH_NDUR;
                    else
                    begin
                        fail = 1'b1; fail_code = ERR_PAIR_SEP;
                    end
                end
            end
            PH_NDUR:
            begin
                if (stat.is_digit)
                    c_cmd.accumulate = 1'b1;
                else if (stat.is_zero && !stat.digit_seen)
                begin
                    c_cmd.start_song = 1'b1;
                    c_cmd.emit       = 1'b1;
                    c_cmd.emit_end   = 1'b1;
                    ph_next          = PH_NAME;
                end
                else if (!stat.dur_ok)
                begin
                    fail = 1'b1; fail_code = ERR_NOTE_DUR;
                end
                else
                begin
                    c_cmd.set_dur   = 1'b1;
                    c_cmd.clear_num = 1'b1;
                    if (stat.pitch_valid)
                    begin
                        c_cmd.load_note = 1'b1;
                        ph_next = PH_SHARP;
                    end
                    else if (stat.is_zero)
                    begin
                        fail = 1'b1; fail_code = ERR_END_CTRL;
                    end
                    else
                    begin
                        c_cmd.set_letter = 1'b1;
                        ph_next = PH_NEQ;
                    end
                end
            end
            PH_SHARP:
            begin
                ph_next = PH_DOT;
                if (stat.is_hash && stat.sharp_ok)
                    c_cmd.pitch_inc = 1'b1;
                else
                    cont = 1'b1;
            end
            PH_DOT:
            begin
                ph_next = PH_OCT;
                c_cmd.clear_num = 1'b1;
                if (stat.is_dot)
                    c_cmd.set_dotted = 1'b1;
                else
                    cont = 1'b1;
            end
            PH_OCT:
            begin
                if (stat.is_digit)
                    c_cmd.accumulate = 1'b1;
                else if (!stat.oct_ok)
                begin
                    fail = 1'b1; fail_code = ERR_NOTE_OCT;
                end
                else if (stat.is_comma)
                begin
                    c_cmd.clear_num = 1'b1;
                    c_cmd.emit      = 1'b1;
                    c_cmd.emit_note = 1'b1;
                    ph_next         = PH_NDUR;
                end
                else if (stat.is_zero)
                begin
                    c_cmd.emit       = 1'b1;
                    c_cmd.emit_note  = 1'b1;
                    c_cmd.emit_end   = 1'b1;
                    c_cmd.start_song = 1'b1;
                    ph_next          = PH_NAME;
                end
                else
                begin
                    fail = 1'b1; fail_code = ERR_NOTE_SEP;
                end
            end
            PH_HALT:
            begin
                if (stat.is_zero)
                begin
                    c_cmd.start_song = 1'b1;
                    ph_next          = PH_NAME;
                end
            end
            default:
                ph_next = PH_HALT;
        endcase

        if (fail)
        begin
            c_cmd.emit     = 1'b1;
            c_cmd.emit_err = fail_code;
            c_cmd.emit_end = stat.is_zero;
            if (stat.is_zero)
            begin
                c_cmd.start_song = 1'b1;
                ph_next          = PH_NAME;
            end
            else
                ph_next = PH_HALT;
        end
        if (c_cmd.start_song)
            c_cmd.div_start = 1'b1;
    end

    always_comb
    begin
        cmd          = step_en ? c_cmd : '0;
        cmd.use_held = (st_reg != ST_IDLE);
        st_next      = st_reg;
        cont_next    = cont_reg;
        unique case (st_reg)
            ST_IDLE, ST_EXEC:
            begin
                if (step_en)
                begin
                    cont_next = cont;
                    if (c_cmd.div_start)
                        st_next = ST_DIV;
                    else if (cont)
                        st_next = ST_EXEC;
                    else
                        st_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    st_next = cont_reg ? ST_EXEC : ST_IDLE;
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            ph_reg   <= PH_NAME;
            cont_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cont_reg <= cont_next;
            if (step_en)
                ph_reg <= ph_next;
        end
    end

endmodule

/* hw/rtl/ringtone_text_note_parser_top.sv */
// ----------------------------------------------------------------------------
// ringtone_text_note_parser_top
// ringtone text parser: characters in, notes with pitch, octave and length out
// ----------------------------------------------------------------------------
// One character beat is taken per idle cycle and most characters are done in
// that cycle; a character that closes an optional part of a tone command is
// held and stepped on through each further part that it passes over. A song
// start and every b= pair run the tempo division, a one bit per cycle divider,
// and the next beat is taken only once it is done. Results sit in an
// output register, and a character beat is taken only while that register is
// empty or being read out in the same cycle.
module ringtone_text_note_parser_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rtnp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rtnp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // char_code
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,   // semitone, note_octave, length_q6, error_code
    output logic [1:0]                        m_tuser,   // note_ready, is_pause
    output logic                              m_tlast    // song_end
);
    import rtnp_pkg::*;

    rtnp_cmd_t        cmd;
    rtnp_stat_t       stat;
    logic             char_capture;
    logic             o_note;
    logic             o_pause;
    logic [3:0]       o_semi;
    logic [OCT_W-1:0] o_oct;
    logic [LEN_W-1:0] o_len;
    logic [ERR_W-1:0] o_err;

    rtnp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .char_capture (char_capture),
        .stat         (stat),
        .cmd          (cmd)
    );

    rtnp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .char_in        (s_tdata),
        .char_capture   (char_capture),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_note_ready (o_note),
        .out_is_pause   (o_pause),
        .out_semitone   (o_semi),
        .out_octave     (o_oct),
        .out_length     (o_len),
        .out_song_end   (m_tlast),
        .out_error      (o_err)
    );

    assign m_tdata = {4'b0000, o_err, o_len, o_oct, o_semi};
    assign m_tuser = {o_pause, o_note};

`ifndef ASSERT_OFF
    a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !stat.div_busy)
        else $error("character taken during tempo division");

    a_note_has_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[35:32] == ERR_NONE)
        else $error("note result carries an error code");

    a_status_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0 && !m_tuser[1])
        else $error("status result carries note fields");

    a_semitone_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[3:0] <= 4'd11 && m_tdata[6:4] >= 3'd4)
        else $error("note pitch or octave out of range");
`endif

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the ringtone text note parser. Song texts go in one character
// per beat and each result is checked field by field against a predictor
// that runs alongside. The run covers directed error cases, setting changes
// and random songs, with idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rtnp_pkg::*;

    typedef enum int {ST_NAME, ST_KEY, ST_EQ, ST_VAL, ST_NDUR, ST_NEQ, ST_NVAL,
                      ST_SHARP, ST_DOT, ST_OCT, ST_HALT} parse_state_t;

    typedef struct packed {
        logic             note_ready;
        logic             is_pause;
        logic [3:0]       semitone;
        logic [2:0]       note_octave;
        logic [LEN_W-1:0] length_q6;
        logic             song_end;
        logic [ERR_W-1:0] error_code;
    } note_res_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    ringtone_text_note_parser_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // predictor state
    int unsigned  reg_oct, reg_dur, reg_tempo;
    parse_state_t pst;
    int unsigned  name_cnt, acc, got_digit, pair_ch;
    int unsigned  dflt_oct, dflt_dur, tempo, whole_ms;
    int unsigned  n_dur, n_pitch, n_pause, n_dotted;

    note_res_t notes_due[$];
    int        n_fail;
    int        n_chars;
    int        n_notes;
    int        n_errs;
    bit        idle_en;
    int        hold_cnt;
    int        rx_gap;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void start_song();
        pst       = ST_NAME;
        name_cnt  = 0;
        acc       = 0;
        got_digit = 0;
        pair_ch   = 0;
        dflt_oct  = reg_oct;
        dflt_dur  = reg_dur;
        tempo     = reg_tempo;
        whole_ms  = 240000 / ((tempo != 0) ? tempo : 1);
        n_dur     = 0;
        n_pitch   = 0;
        n_pause   = 0;
        n_dotted  = 0;
    endfunction

    function automatic bit dur_ok(int unsigned d);
        return d != 0 && d <= 32 && (d & (d - 1)) == 0;
    endfunction

    function automatic note_res_t error_res(int unsigned code, bit [7:0] c);
        note_res_t r;
        r            = '0;
        r.error_code = code[3:0];
        if (c == CH_END)
        begin
            start_song();
            r.song_end = 1'b1;
        end
        else
            pst = ST_HALT;
        return r;
    endfunction

    function automatic int unsigned pair_check();
        if (!got_digit)
            return ERR_NO_DIGITS;
        if (pair_ch == CH_LO_O)
        begin
            if (acc < 4 || acc > 7)
                return ERR_OCT_VAL;
            dflt_oct = acc;
        end
        else if (pair_ch == CH_LO_D)
        begin
            if (!dur_ok(acc))
                return ERR_DUR_VAL;
            dflt_dur = acc;
        end
        else if (pair_ch == CH_LO_B)
        begin
            if (acc == 0 || acc > 65535)
                return ERR_TEMPO_VAL;
            tempo    = acc;
            whole_ms = 240000 / tempo;
        end
        return ERR_NONE;
    endfunction

    function automatic int pitch_of(bit [7:0] c);
        case (c)
            "C": return 0;
            "D": return 2;
            "E": return 4;
            "F": return 5;
            "G": return 7;
            "A": return 9;
            "B": return 11;
            "P": return 12;
            default: return -1;
        endcase
    endfunction

    function automatic note_res_t note_res(int unsigned oct, bit fin);
        note_res_t   r;
        int unsigned mul;
        r             = '0;
        mul           = n_dotted ? 96 : 64;
        r.note_ready  = 1'b1;
        r.is_pause    = n_pause[0];
        r.semitone    = n_pause ? 4'd0 : n_pitch[3:0];
        r.note_octave = oct[2:0];
        r.length_q6   = (n_dur != 0) ? LEN_W'((whole_ms * mul) / n_dur) : '0;
        r.song_end    = fin;
        return r;
    endfunction

    // returns 1 when the character produces a result
    function automatic bit parse_char(bit [7:0] c, output note_res_t r);
        bit          dig;
        int unsigned e;
        int unsigned v;
        int          p;
        dig = c >= CH_ZERO && c <= CH_NINE;
        r   = '0;
        if (c == CH_SPACE)
            return 0;
        forever
        begin
            case (pst)
                ST_NAME:
                begin
                    if (c == CH_END)
                    begin
                        r = error_res(ERR_END_NAME, c);
                        return 1;
                    end
                    if (c == CH_COLON)
                    begin
                        pst = ST_KEY;
                        return 0;
                    end
                    if (name_cnt >= MAX_NAME_LEN)
                    begin
                        r = error_res(ERR_NAME_LONG, c);
                        return 1;
                    end
                    name_cnt++;
                    return 0;
                end
                ST_KEY:
                begin
                    if (c == CH_END)
                    begin
                        r = error_res(ERR_END_CTRL, c);
                        return 1;
                    end
                    acc       = 0;
                    got_digit = 0;
                    if (c == CH_COLON)
                    begin
                        pst = ST_NDUR;
                        return 0;
                    end
                    pair_ch = c;
                    pst     = ST_EQ;
                    return 0;
                end
                ST_EQ, ST_NEQ:
                begin
                    pst = (pst == ST_EQ) ? ST_VAL : ST_NVAL;
                    if (c == CH_EQ)
                        return 0;
                end
                ST_VAL, ST_NVAL:
                begin
                    if (dig)
                    begin
                        v         = acc * 10 + (c - CH_ZERO);
                        acc       = (v > ACC_MAX) ? ACC_MAX : v;
                        got_digit = 1;
                        return 0;
                    end
                    e = pair_check();
                    if (e != ERR_NONE)
                    begin
                        r = error_res(e, c);
                        return 1;
                    end
                    acc       = 0;
                    got_digit = 0;
                    if (pst == ST_VAL)
                    begin
                        if (c == CH_COMMA)
                        begin
                            pst = ST_KEY;
                            return 0;
                        end
                        if (c == CH_COLON)
                        begin
                            pst = ST_NDUR;
                            return 0;
                        end
                        r = error_res(ERR_PAIR_SEP, c);
                        return 1;
                    end
                    pst = ST_NDUR;
                    if (c == CH_COMMA)
                        return 0;
                end
                ST_NDUR:
                begin
                    if (dig)
                    begin
                        v         = acc * 10 + (c - CH_ZERO);
                        acc       = (v > ACC_MAX) ? ACC_MAX : v;
                        got_digit = 1;
                        return 0;
                    end
                    if (c == CH_END && !got_digit)
                    begin
                        start_song();
                        r.song_end = 1'b1;
                        return 1;
                    end
                    v = (acc != 0) ? acc : dflt_dur;
                    if (!dur_ok(v))
                    begin
                        r = error_res(ERR_NOTE_DUR, c);
                        return 1;
                    end
                    n_dur     = v;
                    p         = pitch_of(c);
                    acc       = 0;
                    got_digit = 0;
                    if (p >= 0)
                    begin
                        n_pause  = (p == 12);
                        n_pitch  = n_pause ? 0 : p;
                        n_dotted = 0;
                        pst      = ST_SHARP;
                        return 0;
                    end
                    if (c == CH_END)
                    begin
                        r = error_res(ERR_END_CTRL, c);
                        return 1;
                    end
                    pair_ch = c;
                    pst     = ST_NEQ;
                    return 0;
                end
                ST_SHARP:
                begin
                    pst = ST_DOT;
                    if (c == CH_HASH && !n_pause && (n_pitch == 0 || n_pitch == 2 ||
                        n_pitch == 5 || n_pitch == 7 || n_pitch == 9))
                    begin
                        n_pitch++;
                        return 0;
                    end
                end
                ST_DOT:
                begin
                    pst       = ST_OCT;
                    acc       = 0;
                    got_digit = 0;
                    if (c == CH_DOT)
                    begin
                        n_dotted = 1;
                        return 0;
                    end
                end
                ST_OCT:
                begin
                    if (dig)
                    begin
                        v         = acc * 10 + (c - CH_ZERO);
                        acc       = (v > ACC_MAX) ? ACC_MAX : v;
                        got_digit = 1;
                        return 0;
                    end
                    v = (acc != 0) ? acc : dflt_oct;
                    if (v < 4 || v > 7)
                    begin
                        r = error_res(ERR_NOTE_OCT, c);
                        return 1;
                    end
                    if (c == CH_COMMA)
                    begin
                        acc       = 0;
                        got_digit = 0;
                        pst       = ST_NDUR;
                        r         = note_res(v, 1'b0);
                        return 1;
                    end
                    if (c == CH_END)
                    begin
                        r = note_res(v, 1'b1);
                        start_song();
                        return 1;
                    end
                    r = error_res(ERR_NOTE_SEP, c);
                    return 1;
                end
                default:
                begin
                    if (c == CH_END)
                        start_song();
                    return 0;
                end
            endcase
        end
    endfunction

    task automatic send_char(bit [7:0] c);
        note_res_t r;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        n_chars++;
        if (parse_char(c, r))
            notes_due.push_back(r);
    endtask

    task automatic send_text(string s, bit close = 1'b1);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        if (close)
            send_char(CH_END);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (notes_due.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[15:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_OCTAVE)
            reg_oct = val & 7;
        else if (idx == CFG_DURATION)
            reg_dur = val & 6'h3f;
        else if (idx == CFG_TEMPO)
            reg_tempo = val & 16'hffff;
    endtask

    function automatic string rand_song();
        string s;
        string letters;
        int    n;
        letters = "CDEFGABP";
        s = "";
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'($urandom_range("a", "z")))};
        s = {s, ":"};
        if ($urandom_range(0, 1))
            s = {s, $sformatf("d=%0d,", 1 << $urandom_range(0, 5))};
        if ($urandom_range(0, 1))
            s = {s, $sformatf("o=%0d,", $urandom_range(4, 7))};
        s = {s, $sformatf("b=%0d:", $urandom_range(1, 400))};
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            if (i != 0)
                s = {s, ","};
            if ($urandom_range(0, 1))
                s = {s, $sformatf("%0d", 1 << $urandom_range(0, 5))};
            s = {s, string'(letters[$urandom_range(0, 7)])};
            if ($urandom_range(0, 2) == 0)
                s = {s, "#"};
            if ($urandom_range(0, 3) == 0)
                s = {s, "."};
            if ($urandom_range(0, 1))
                s = {s, $sformatf("%0d", $urandom_range(4, 7))};
            if ($urandom_range(0, 5) == 0)
                s = {s, " "};
        end
        // occasional corruption with any non-zero byte value
        if ($urandom_range(0, 7) == 0)
            s[$urandom_range(0, s.len() - 1)] = byte'($urandom_range(1, 255));
        return s;
    endfunction

    task automatic test_directed();
        send_text("tune:d=8,o=5,b=120:4C#.6,P,E,32B.,A#7,D#,2F");
        send_text("ab");
        send_text("abcdefghijk:");
        send_text("x:d=4");
        send_text("x:d=,");
        send_text("x:o=9,");
        send_text("x:d=3,");
        send_text("x:b=0,");
        send_text("x:b=99999999:");
        send_text("x:d=4;C");
        send_text("x::3C");
        send_text("x::C8,");
        send_text("x::C;D");
        send_text("x::");
        send_text("x::C0,0C,b=200,D,d16,E#,P#");
        send_text("x::C,o=4,");
        drain();
    endtask

    task automatic test_registers();
        write_reg(CFG_OCTAVE, 4);
        write_reg(CFG_DURATION, 1);
        write_reg(CFG_TEMPO, 65535);
        send_char(CH_END);
        send_text("s::C,D.,P");
        drain();
        write_reg(CFG_OCTAVE, 7);
        write_reg(CFG_DURATION, 32);
        write_reg(CFG_TEMPO, 1);
        send_char(CH_END);
        send_text("s::C,D.,P");
        drain();
        write_reg(CFG_TEMPO, 0);
        write_reg(CFG_OCTAVE, 2);
        write_reg(CFG_DURATION, 12);
        send_char(CH_END);
        send_text("s::C");
        send_text("s::4C");
        send_text("s:o=5:C,d=2,E");
        drain();
        write_reg(CFG_OCTAVE, 6);
        write_reg(CFG_DURATION, 4);
        write_reg(CFG_TEMPO, 63);
        send_char(CH_END);
        drain();
    endtask

    task automatic test_random(int n_chars_goal);
        int start;
        start = n_chars;
        while (n_chars - start < n_chars_goal)
        begin
            if ($urandom_range(0, 9) == 0)
                send_char(byte'($urandom_range(0, 255)));
            else
                send_text(rand_song());
        end
        send_char(CH_END);
    endtask

    task automatic test_output_stall();
        hold_cnt = 300;
        for (int i = 0; i < 6; i++)
            send_text("st::C,D,E,F,G,A,B,P");
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        n_fail    = 0;
        n_chars   = 0;
        n_notes   = 0;
        n_errs    = 0;
        idle_en   = 1'b1;
        hold_cnt  = 0;
        reg_oct   = OCT_RESET;
        reg_dur   = DUR_RESET;
        reg_tempo = TEMPO_RESET;
        start_song();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_registers();
        test_random(450);
        drain();
        test_output_stall();
        idle_en = 1'b0;
        test_random(250);
        drain();
        $display("sent %0d characters, checked %0d notes and %0d error results",
                 n_chars, n_notes, n_errs);
        $display("covered error codes, setting extremes, random songs and long output stall");
        if (n_fail == 0 && notes_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end
        else if (hold_cnt > 0)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
        else if (rx_gap > 0)
        begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end
        else if (idle_en && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            rx_gap   <= $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        note_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (notes_due.size() == 0)
            begin
                $error("result beat with nothing expected");
                n_fail++;
            end
            else
            begin
                want = notes_due.pop_front();
                if (want.note_ready)
                    n_notes++;
                if (want.error_code != ERR_NONE)
                    n_errs++;
                if (m_tuser[0] !== want.note_ready)
                begin
                    $error("note_ready exp %0d got %0d", want.note_ready, m_tuser[0]);
                    n_fail++;
                end
                if (m_tuser[1] !== want.is_pause)
                begin
                    $error("is_pause exp %0d got %0d", want.is_pause, m_tuser[1]);
                    n_fail++;
                end
                if (m_tdata[3:0] !== want.semitone)
                begin
                    $error("semitone exp %0d got %0d", want.semitone, m_tdata[3:0]);
                    n_fail++;
                end
                if (m_tdata[6:4] !== want.note_octave)
                begin
                    $error("note_octave exp %0d got %0d", want.note_octave, m_tdata[6:4]);
                    n_fail++;
                end
                if (m_tdata[31:7] !== want.length_q6)
                begin
                    $error("length_q6 exp %0d got %0d", want.length_q6, m_tdata[31:7]);
                    n_fail++;
                end
                if (m_tlast !== want.song_end)
                begin
                    $error("song_end exp %0d got %0d", want.song_end, m_tlast);
                    n_fail++;
                end
                if (m_tdata[35:32] !== want.error_code)
                begin
                    $error("error_code exp %0d got %0d", want.error_code, m_tdata[35:32]);
                    n_fail++;
                end
            end
        end
    end

endmodule

/* files.f */
hw/rtl/rtnp_pkg.sv
hw/rtl/rtnp_div.sv
hw/rtl/rtnp_dp.sv
hw/rtl/rtnp_ctrl.sv
hw/rtl/ringtone_text_note_parser_top.sv
test/tb_top.sv
